@@ rtl/assert_macros.svh @@
// Assertion macros shared by the decode/execute unit RTL.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property with the reset held as a disable condition.
`define RDX_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rdx assertion failed");
// Checked property that is also evaluated while reset is high.
`define RDX_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rdx assertion failed");
`else
`define RDX_ASSERT(lbl, clk, rst, prop)
`define RDX_ASSERT_NR(lbl, clk, prop)
`endif

`endif

@@ rtl/rdx_pkg.sv @@
// Shared constants and types for the RV64IM decode/execute unit.
// No dependencies; rdx_front, rdx_queue, rdx_back and the top level import this package.
package rdx_pkg;

   localparam int XLEN            = 64;
   localparam int ILEN            = 32;
   localparam int RDX_QUEUE_DEPTH = 2;

   // Major opcodes.
   localparam logic [6:0] OPC_OP      = 7'h33;
   localparam logic [6:0] OPC_OP32    = 7'h3b;
   localparam logic [6:0] OPC_LOAD    = 7'h03;
   localparam logic [6:0] OPC_OPIMM   = 7'h13;
   localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
   localparam logic [6:0] OPC_JALR    = 7'h67;
   localparam logic [6:0] OPC_SYSTEM  = 7'h73;
   localparam logic [6:0] OPC_STORE   = 7'h23;
   localparam logic [6:0] OPC_BRANCH  = 7'h63;
   localparam logic [6:0] OPC_AUIPC   = 7'h17;
   localparam logic [6:0] OPC_LUI     = 7'h37;
   localparam logic [6:0] OPC_JAL     = 7'h6f;

   localparam logic [31:0] ECALL_WORD = 32'h00000073;

   // funct7 / funct6 codes.
   localparam logic [6:0] F7_BASE   = 7'h00;
   localparam logic [6:0] F7_ALT    = 7'h20;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [5:0] F6_SRL    = 6'h00;
   localparam logic [5:0] F6_SRA    = 6'h10;

   // funct3 codes.
   localparam logic [2:0] F3_ADD_SUB = 3'd0;
   localparam logic [2:0] F3_SLL     = 3'd1;
   localparam logic [2:0] F3_SLT     = 3'd2;
   localparam logic [2:0] F3_XOR     = 3'd4;
   localparam logic [2:0] F3_SRL_SRA = 3'd5;
   localparam logic [2:0] F3_OR      = 3'd6;
   localparam logic [2:0] F3_AND     = 3'd7;
   localparam logic [2:0] F3_MUL     = 3'd0;
   localparam logic [2:0] F3_MULH    = 3'd1;
   localparam logic [2:0] F3_DIV     = 3'd4;
   localparam logic [2:0] F3_REM     = 3'd6;
   localparam logic [2:0] F3_BEQ     = 3'd0;
   localparam logic [2:0] F3_BNE     = 3'd1;
   localparam logic [2:0] F3_BLT     = 3'd4;
   localparam logic [2:0] F3_BGE     = 3'd5;
   localparam logic [2:0] F3_JALR    = 3'd0;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ADD,
      OP_SUB,
      OP_SLL,
      OP_SLT,
      OP_XOR,
      OP_SRL,
      OP_SRA,
      OP_OR,
      OP_AND,
      OP_LINK,
      OP_MUL,
      OP_MULH,
      OP_DIV,
      OP_REM
   } alu_op_type;

   typedef enum logic [2:0] {
      BR_NONE,
      BR_JUMP,
      BR_EQ,
      BR_NE,
      BR_LT,
      BR_GE
   } br_type;

   typedef enum logic [1:0] {
      BS_IDLE,
      BS_MUL,
      BS_DIV,
      BS_DONE
   } bstate_type;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      logic             known;
      alu_op_type       op;
      br_type           br;
      logic             word;
      logic [4:0]       rd;
      logic             reg_write;
      logic             mem_read;
      logic             mem_write;
      logic [1:0]       size;
      logic             halt;
      logic [XLEN-1:0]  a;
      logic [XLEN-1:0]  b;
      logic [XLEN-1:0]  seq;
      logic [XLEN-1:0]  target;
   } decoded_type;

endpackage

@@ rtl/rdx_channels.sv @@
// Handshake channel interfaces for requests and responses of the unit.
// Depends on nothing; used by the front, back and top level.
interface rdx_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr;
   logic [63:0] pc;
   logic [63:0] rs1_value;
   logic [63:0] rs2_value;

   modport source (output valid, output instr, output pc, output rs1_value,
                   output rs2_value, input ready);
   modport sink (input valid, input instr, input pc, input rs1_value,
                 input rs2_value, output ready);
endinterface

interface rdx_rsp_if;
   logic        valid;
   logic        ready;
   logic        known_op;
   logic [63:0] result;
   logic [4:0]  dest_reg;
   logic        reg_write;
   logic        mem_read;
   logic        mem_write;
   logic [1:0]  access_size;
   logic [63:0] next_pc;
   logic        branch_taken;
   logic        halt;

   modport source (output valid, output known_op, output result, output dest_reg,
                   output reg_write, output mem_read, output mem_write,
                   output access_size, output next_pc, output branch_taken,
                   output halt, input ready);
   modport sink (input valid, input known_op, input result, input dest_reg,
                 input reg_write, input mem_read, input mem_write,
                 input access_size, input next_pc, input branch_taken,
                 input halt, output ready);
endinterface

@@ rtl/rdx_front.sv @@
// Front end: decodes each request and pushes the classified item to the queue.
// Depends on rdx_pkg and the request channel interface.
module rdx_front import rdx_pkg::*; (
   rdx_req_if.sink     req,
   input  logic        full,
   output logic        push,
   output decoded_type push_item
);

   logic [31:0]     instr;
   logic [6:0]      opcode;
   logic [2:0]      f3;
   logic [6:0]      f7;
   logic [5:0]      f6;
   logic [XLEN-1:0] imm_i;
   logic [XLEN-1:0] imm_s;
   logic [XLEN-1:0] imm_b;
   logic [XLEN-1:0] imm_u;
   logic [XLEN-1:0] imm_j;
   logic [XLEN-1:0] rs1_sext;
   logic [XLEN-1:0] rs1_zext;
   logic [XLEN-1:0] rs2_sext;
   logic [XLEN-1:0] tgt_base;
   logic [XLEN-1:0] tgt_imm;
   logic [XLEN-1:0] tgt_sum;
   logic            clear_lsb;
   logic            ok;
   alu_op_type      op;
   br_type          br;
   logic            word;
   logic            wr;
   logic            mr;
   logic            mw;
   logic            hl;
   logic [1:0]      size;
   logic [XLEN-1:0] a_sel;
   logic [XLEN-1:0] b_sel;

   assign req.ready = !full;
   assign push      = req.valid && !full;

   assign instr  = req.instr;
   assign opcode = instr[6:0];
   assign f3     = instr[14:12];
   assign f7     = instr[31:25];
   assign f6     = instr[31:26];

   assign imm_i = {{52{instr[31]}}, instr[31:20]};
   assign imm_s = {{52{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b = {{51{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_u = {{32{instr[31]}}, instr[31:12], 12'b0};
   assign imm_j = {{43{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

   assign rs1_sext = {{32{req.rs1_value[31]}}, req.rs1_value[31:0]};
   assign rs1_zext = {32'b0, req.rs1_value[31:0]};
   assign rs2_sext = {{32{req.rs2_value[31]}}, req.rs2_value[31:0]};

   always_comb begin
      ok        = 1'b0;
      op        = OP_NONE;
      br        = BR_NONE;
      word      = 1'b0;
      wr        = 1'b0;
      mr        = 1'b0;
      mw        = 1'b0;
      hl        = 1'b0;
      size      = 2'b0;
      a_sel     = req.rs1_value;
      b_sel     = req.rs2_value;
      tgt_base  = req.pc;
      tgt_imm   = imm_b;
      clear_lsb = 1'b0;

      case (opcode)
         OPC_OP: begin
            ok = 1'b1;
            case (f7)
               F7_BASE: begin
                  case (f3)
                     F3_ADD_SUB: op = OP_ADD;
                     F3_SLL:     op = OP_SLL;
                     F3_SLT:     op = OP_SLT;
                     F3_XOR:     op = OP_XOR;
                     F3_SRL_SRA: op = OP_SRL;
                     F3_OR:      op = OP_OR;
                     F3_AND:     op = OP_AND;
                     default:    ok = 1'b0;
                  endcase
               end
               F7_ALT: begin
                  if (f3 == F3_ADD_SUB) op = OP_SUB;
                  else if (f3 == F3_SRL_SRA) op = OP_SRA;
                  else ok = 1'b0;
               end
               F7_MULDIV: begin
                  case (f3)
                     F3_MUL:  op = OP_MUL;
                     F3_MULH: op = OP_MULH;
                     F3_DIV:  op = OP_DIV;
                     F3_REM:  op = OP_REM;
                     default: ok = 1'b0;
                  endcase
               end
               default: ok = 1'b0;
            endcase
            wr = ok;
         end
         OPC_OP32: begin
            ok   = 1'b1;
            word = 1'b1;
            b_sel = rs2_sext;
            if (f7 == F7_BASE && f3 == F3_ADD_SUB) op = OP_ADD;
            else if (f7 == F7_ALT && f3 == F3_ADD_SUB) op = OP_SUB;
            else if (f7 == F7_MULDIV && f3 == F3_MUL) op = OP_MUL;
            else if (f7 == F7_BASE && f3 == F3_SLL) op = OP_SLL;
            else if (f7 == F7_BASE && f3 == F3_SRL_SRA) op = OP_SRL;
            else if (f7 == F7_ALT && f3 == F3_SRL_SRA) op = OP_SRA;
            else if (f7 == F7_MULDIV && f3 == F3_DIV) op = OP_DIV;
            else ok = 1'b0;
            // A logical word shift sees the low word zero-extended.
            a_sel = (op == OP_SRL) ? rs1_zext : rs1_sext;
            wr = ok;
         end
         OPC_LOAD: begin
            if (!f3[2]) begin
               ok    = 1'b1;
               wr    = 1'b1;
               mr    = 1'b1;
               size  = f3[1:0];
               op    = OP_ADD;
               b_sel = imm_i;
            end
         end
         OPC_OPIMM: begin
            ok    = 1'b1;
            b_sel = imm_i;
            case (f3)
               F3_ADD_SUB: op = OP_ADD;
               F3_SLT:     op = OP_SLT;
               F3_XOR:     op = OP_XOR;
               F3_OR:      op = OP_OR;
               F3_AND:     op = OP_AND;
               F3_SLL: begin
                  if (f6 == F6_SRL) op = OP_SLL;
                  else ok = 1'b0;
               end
               F3_SRL_SRA: begin
                  if (f6 == F6_SRL) op = OP_SRL;
                  else if (f6 == F6_SRA) op = OP_SRA;
                  else ok = 1'b0;
               end
               default: ok = 1'b0;
            endcase
            wr = ok;
         end
         OPC_OPIMM32: begin
            ok    = 1'b1;
            word  = 1'b1;
            b_sel = imm_i;
            if (f3 == F3_ADD_SUB) op = OP_ADD;
            else if (f3 == F3_SLL && f7 == F7_BASE) op = OP_SLL;
            else if (f3 == F3_SRL_SRA && f7 == F7_BASE) op = OP_SRL;
            else if (f3 == F3_SRL_SRA && f7 == F7_ALT) op = OP_SRA;
            else ok = 1'b0;
            a_sel = (op == OP_SRL) ? rs1_zext : rs1_sext;
            wr = ok;
         end
         OPC_JALR: begin
            if (f3 == F3_JALR) begin
               ok        = 1'b1;
               wr        = 1'b1;
               op        = OP_LINK;
               br        = BR_JUMP;
               tgt_base  = req.rs1_value;
               tgt_imm   = imm_i;
               clear_lsb = 1'b1;
            end
         end
         OPC_SYSTEM: begin
            if (instr == ECALL_WORD) begin
               ok = 1'b1;
               hl = 1'b1;
            end
         end
         OPC_STORE: begin
            if (!f3[2]) begin
               ok    = 1'b1;
               mw    = 1'b1;
               size  = f3[1:0];
               op    = OP_ADD;
               b_sel = imm_s;
            end
         end
         OPC_BRANCH: begin
            ok = 1'b1;
            case (f3)
               F3_BEQ:  br = BR_EQ;
               F3_BNE:  br = BR_NE;
               F3_BLT:  br = BR_LT;
               F3_BGE:  br = BR_GE;
               default: ok = 1'b0;
            endcase
         end
         OPC_AUIPC: begin
            ok    = 1'b1;
            wr    = 1'b1;
            op    = OP_ADD;
            a_sel = req.pc;
            b_sel = imm_u;
         end
         OPC_LUI: begin
            ok    = 1'b1;
            wr    = 1'b1;
            op    = OP_ADD;
            a_sel = '0;
            b_sel = imm_u;
         end
         OPC_JAL: begin
            ok      = 1'b1;
            wr      = 1'b1;
            op      = OP_LINK;
            br      = BR_JUMP;
            tgt_imm = imm_j;
         end
         default: ok = 1'b0;
      endcase
   end

   assign tgt_sum = tgt_base + tgt_imm;

   always_comb begin
      push_item        = '0;
      push_item.seq    = req.pc + XLEN'(4);
      push_item.target = {tgt_sum[XLEN-1:1], tgt_sum[0] & !clear_lsb};
      push_item.a      = a_sel;
      push_item.b      = b_sel;
      // An unsupported encoding leaves every control at zero.
      if (ok) begin
         push_item.known     = 1'b1;
         push_item.op        = op;
         push_item.br        = br;
         push_item.word      = word;
         push_item.rd        = wr ? instr[11:7] : 5'b0;
         push_item.reg_write = wr;
         push_item.mem_read  = mr;
         push_item.mem_write = mw;
         push_item.size      = size;
         push_item.halt      = hl;
      end
   end

endmodule

@@ rtl/rdx_queue.sv @@
// Small FIFO that decouples the decode front from the execute back.
// Depends on rdx_pkg for the item type.
`include "assert_macros.svh"

module rdx_queue import rdx_pkg::*; #(
   parameter int DEPTH = RDX_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  decoded_type push_item,
   output logic        full,
   input  logic        pop,
   output logic        pop_valid,
   output decoded_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   decoded_type      slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_item;
   end

   `RDX_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `RDX_ASSERT(a_no_pop_empty, clock, reset, pop |-> (count_ff != '0))
   `RDX_ASSERT_NR(a_reset_empty, clock, reset |=> (count_ff == '0))

endmodule

@@ rtl/rdx_back.sv @@
// Execute back end: ALU, branch resolution, sequential multiply and divide,
// and the response output register. Depends on rdx_pkg and the response channel.
`include "assert_macros.svh"

module rdx_back import rdx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  decoded_type q_item,
   output logic        q_pop,
   rdx_rsp_if.source   rsp
);

   localparam int CNT_W = $clog2(XLEN);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(4);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(XLEN - 1);

   typedef struct packed {
      logic            known_op;
      logic [XLEN-1:0] result;
      logic [4:0]      dest_reg;
      logic            reg_write;
      logic            mem_read;
      logic            mem_write;
      logic [1:0]      access_size;
      logic [XLEN-1:0] next_pc;
      logic            branch_taken;
      logic            halt;
   } rsp_data_type;

   bstate_type        state_ff, state_in;
   decoded_type       item_ff, item_in;
   logic [2*XLEN-1:0] acc_ff, acc_in;
   logic [XLEN-1:0]   prod_ff, prod_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [XLEN-1:0]   quo_ff, quo_in;
   logic [XLEN-1:0]   rem_ff, rem_in;
   logic [XLEN-1:0]   dvs_ff, dvs_in;
   logic              negq_ff, negq_in;
   logic              negr_ff, negr_in;
   logic              dz_ff, dz_in;
   logic              out_v_ff, out_v_in;
   rsp_data_type      out_ff, out_in;

   logic              out_free;
   logic [XLEN-1:0]   simple_res;
   logic [XLEN-1:0]   unit_raw;
   logic [XLEN-1:0]   unit_res;
   logic [5:0]        shamt;
   logic [XLEN-1:0]   alu_raw;
   logic [31:0]       a_half;
   logic [31:0]       b_half;
   logic [CNT_W-1:0]  cnt_m1;
   logic [2*XLEN-1:0] pp_shifted;
   logic [XLEN-1:0]   rem_sh;
   logic [XLEN-1:0]   mulh_hi;
   logic              q_is_mul;
   logic              q_is_div;

   function automatic logic [XLEN-1:0] sext_word(input logic [XLEN-1:0] v);
      return {{(XLEN-32){v[31]}}, v[31:0]};
   endfunction

   function automatic rsp_data_type make_rsp(input decoded_type d,
                                             input logic [XLEN-1:0] r);
      rsp_data_type o;
      logic         tk;
      case (d.br)
         BR_JUMP: tk = 1'b1;
         BR_EQ:   tk = (d.a == d.b);
         BR_NE:   tk = (d.a != d.b);
         BR_LT:   tk = ($signed(d.a) < $signed(d.b));
         BR_GE:   tk = !($signed(d.a) < $signed(d.b));
         default: tk = 1'b0;
      endcase
      o.known_op     = d.known;
      o.result       = r;
      o.dest_reg     = d.rd;
      o.reg_write    = d.reg_write;
      o.mem_read     = d.mem_read;
      o.mem_write    = d.mem_write;
      o.access_size  = d.size;
      o.next_pc      = tk ? d.target : d.seq;
      o.branch_taken = tk;
      o.halt         = d.halt;
      return o;
   endfunction

   // Combinational ALU on the item at the head of the queue.
   assign shamt = q_item.word ? {1'b0, q_item.b[4:0]} : q_item.b[5:0];

   always_comb begin
      case (q_item.op)
         OP_ADD:  alu_raw = q_item.a + q_item.b;
         OP_SUB:  alu_raw = q_item.a - q_item.b;
         OP_SLL:  alu_raw = q_item.a << shamt;
         OP_SLT:  alu_raw = {{(XLEN-1){1'b0}}, $signed(q_item.a) < $signed(q_item.b)};
         OP_XOR:  alu_raw = q_item.a ^ q_item.b;
         OP_SRL:  alu_raw = q_item.a >> shamt;
         OP_SRA:  alu_raw = $unsigned($signed(q_item.a) >>> shamt);
         OP_OR:   alu_raw = q_item.a | q_item.b;
         OP_AND:  alu_raw = q_item.a & q_item.b;
         OP_LINK: alu_raw = q_item.seq;
         default: alu_raw = '0;
      endcase
      simple_res = q_item.word ? sext_word(alu_raw) : alu_raw;
   end

   assign q_is_mul = (q_item.op == OP_MUL) || (q_item.op == OP_MULH);
   assign q_is_div = (q_item.op == OP_DIV) || (q_item.op == OP_REM);

   // Multiply: four 32x32 partial products, one per cycle, each accumulated in the following cycle.
   assign a_half = cnt_ff[1] ? item_ff.a[XLEN-1:32] : item_ff.a[31:0];
   assign b_half = cnt_ff[0] ? item_ff.b[XLEN-1:32] : item_ff.b[31:0];
   assign cnt_m1 = cnt_ff - CNT_W'(1);

   always_comb begin
      case (cnt_m1[1:0])
         2'd0:    pp_shifted = {{XLEN{1'b0}}, prod_ff};
         2'd3:    pp_shifted = {prod_ff, {XLEN{1'b0}}};
         default: pp_shifted = {32'b0, prod_ff, 32'b0};
      endcase
   end

   // Signed high product from the unsigned one.
   assign mulh_hi = acc_ff[2*XLEN-1:XLEN]
                    - (item_ff.a[XLEN-1] ? item_ff.b : '0)
                    - (item_ff.b[XLEN-1] ? item_ff.a : '0);

   assign rem_sh = {rem_ff[XLEN-2:0], quo_ff[XLEN-1]};

   always_comb begin
      case (item_ff.op)
         OP_MUL:  unit_raw = acc_ff[XLEN-1:0];
         OP_MULH: unit_raw = mulh_hi;
         OP_DIV:  unit_raw = dz_ff ? '1 : (negq_ff ? -quo_ff : quo_ff);
         OP_REM:  unit_raw = dz_ff ? item_ff.a : (negr_ff ? -rem_ff : rem_ff);
         default: unit_raw = '0;
      endcase
      unit_res = item_ff.word ? sext_word(unit_raw) : unit_raw;
   end

   assign out_free = !out_v_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      negq_in  = negq_ff;
      negr_in  = negr_ff;
      dz_in    = dz_ff;
      out_v_in = out_v_ff && !rsp.ready;
      out_in   = out_ff;
      q_pop    = 1'b0;

      case (state_ff)
         BS_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               if (q_is_mul) begin
                  item_in  = q_item;
                  acc_in   = '0;
                  cnt_in   = '0;
                  state_in = BS_MUL;
               end else if (q_is_div) begin
                  item_in  = q_item;
                  quo_in   = q_item.a[XLEN-1] ? -q_item.a : q_item.a;
                  dvs_in   = q_item.b[XLEN-1] ? -q_item.b : q_item.b;
                  rem_in   = '0;
                  negq_in  = q_item.a[XLEN-1] ^ q_item.b[XLEN-1];
                  negr_in  = q_item.a[XLEN-1];
                  dz_in    = (q_item.b == '0);
                  cnt_in   = '0;
                  state_in = BS_DIV;
               end else begin
                  out_v_in = 1'b1;
                  out_in   = make_rsp(q_item, simple_res);
               end
            end
         end
         BS_MUL: begin
            if (cnt_ff != MUL_LAST) prod_in = a_half * b_half;
            if (cnt_ff != '0) acc_in = acc_ff + pp_shifted;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == MUL_LAST) state_in = BS_DONE;
         end
         BS_DIV: begin
            // One restoring step per cycle on the magnitudes.
            if (rem_sh >= dvs_ff) begin
               rem_in = rem_sh - dvs_ff;
               quo_in = {quo_ff[XLEN-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[XLEN-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) state_in = BS_DONE;
         end
         BS_DONE: begin
            if (out_free) begin
               out_v_in = 1'b1;
               out_in   = make_rsp(item_ff, unit_res);
               state_in = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BS_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      dz_ff   <= dz_in;
      out_ff  <= out_in;
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.known_op     = out_ff.known_op;
   assign rsp.result       = out_ff.result;
   assign rsp.dest_reg     = out_ff.dest_reg;
   assign rsp.reg_write    = out_ff.reg_write;
   assign rsp.mem_read     = out_ff.mem_read;
   assign rsp.mem_write    = out_ff.mem_write;
   assign rsp.access_size  = out_ff.access_size;
   assign rsp.next_pc      = out_ff.next_pc;
   assign rsp.branch_taken = out_ff.branch_taken;
   assign rsp.halt         = out_ff.halt;

   `RDX_ASSERT(a_pop_only_idle, clock, reset, (state_ff != BS_IDLE) |-> !q_pop)
   `RDX_ASSERT(a_mul_ends, clock, reset, (state_ff == BS_MUL && cnt_ff == MUL_LAST) |=> (state_ff == BS_DONE))
   `RDX_ASSERT(a_done_writes, clock, reset, (state_ff == BS_DONE && out_free) |=> (out_v_ff && state_ff == BS_IDLE))

endmodule

@@ rtl/rv64_decode_execute_unit.sv @@
// RV64IM decode/execute unit: front decoder, queue and execute back end.
// Uses rdx_pkg, the channel interfaces, rdx_front, rdx_queue and rdx_back.
//
// The req channel carries one instruction word with its pc and both source
// register values; the rsp channel returns one result per request, in order:
// known_op, result, dest_reg, write/memory controls, access_size, next_pc,
// branch_taken and halt. Both use valid/ready; a transfer happens on a clock
// edge with both high.
// A request is decoded as it is accepted and written into a two-entry queue.
// ALU, load/store address, branch, jump, lui/auipc and ecall requests leave
// the queue one per cycle while rsp.ready is high, sustaining one request per
// clock; each passes through a queue slot and then the output register.
// Multiplies run on a shared 32x32 multiplier over four partial products and
// occupy the back end through its BS_MUL and BS_DONE states; divides and
// remainders use a one-bit-per-cycle restoring divider and occupy it through
// BS_DIV and BS_DONE. Meanwhile the front keeps accepting until the queue fills.
// Reset (synchronous, active high) empties the queue and the output register.
// When rsp.ready is low the response holds, the back end stops taking from the
// queue, and req.ready falls once the queue is full.
module rv64_decode_execute_unit import rdx_pkg::*; #(
   parameter int QUEUE_DEPTH = RDX_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   rdx_req_if.sink   req,
   rdx_rsp_if.source rsp
);

   logic        push;
   logic        full;
   decoded_type push_item;
   logic        pop;
   logic        pop_valid;
   decoded_type pop_item;

   rdx_front u_front (
      .req       (req),
      .full      (full),
      .push      (push),
      .push_item (push_item)
   );

   rdx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   rdx_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (pop_valid),
      .q_item  (pop_item),
      .q_pop   (pop),
      .rsp     (rsp)
   );

endmodule
